// File: hdl/particle_constraint_resolver_assert.svh
// Assertion macros for the particle constraint resolver.
// Clocked on i_clk, disabled while i_rst_n is low; empty under SYNTHESIS.
`ifndef PARTICLE_CONSTRAINT_RESOLVER_ASSERT_SVH
`define PARTICLE_CONSTRAINT_RESOLVER_ASSERT_SVH
`ifndef SYNTHESIS
`define PCR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PCR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PCR_ASSERT_IMP(lbl, ante, cons, msg)
`define PCR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/pcr_pkg.sv
// Shared types, codes and helpers of the particle constraint resolver.
// No dependencies; used by the cells and the top level.
package pcr_pkg;

    localparam logic REQ_PAIR  = 1'b0;
    localparam logic REQ_WORLD = 1'b1;

    localparam logic [1:0] IDX_CENTER_X = 2'd0;
    localparam logic [1:0] IDX_CENTER_Y = 2'd1;
    localparam logic [1:0] IDX_RADIUS   = 2'd2;

    localparam logic [30:0] WORLD_RADIUS_RST = 31'd65536;

    // item state carried along the whole chain
    typedef struct packed {
        logic               req_type;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic [23:0]        ar;
        logic [24:0]        rs;
        logic               sgn_x;
        logic               sgn_y;
        logic [32:0]        mag_x;
        logic [32:0]        mag_y;
        logic               hit;
        logic               zero;
        logic               moved;
        logic               degen;
        logic               m_neg;
        logic [30:0]        m_mag;
        logic [33:0]        divisor;
    } t_pay;

    // square root partials: radicand bits still to enter, remainder, root so far
    typedef struct packed {
        logic [65:0] rad;
        logic [34:0] rem;
        logic [32:0] root;
    } t_sq;

    // one divider lane: remainder, dividend bits still to enter, quotient so far
    typedef struct packed {
        logic [34:0] rem;
        logic [31:0] num;
        logic [31:0] quo;
    } t_dl;

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] res;
        if (v > 34'sd2147483647) begin
            res = 32'h7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// File: hdl/particle_constraint_resolver.sv
// Particle constraint resolver: pair overlap and world boundary correction.
// Depends on pcr_pkg, pcr_sqrt_cell, pcr_div_cell and the assertion macros.
//
// One beat enters per clock while the chain advances. The chain holds three
// front stages (difference, squares, sum), 33 square root cells (one root bit
// each), a decision stage, a multiply stage, 32 divider cells (one quotient
// bit each for x and y together) and the output register. The whole chain
// advances whenever the output register is empty or being taken, so a stall
// on the result side holds every stage in place.
`include "particle_constraint_resolver_assert.svh"
module particle_constraint_resolver import pcr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // a_x, a_y, a_radius, b_x, b_y, b_radius
    input  logic [175:0] i_s_axis_tdata,
    // req_type
    input  logic [0:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // new_a_x, new_a_y, new_b_x, new_b_y
    output logic [127:0] o_m_axis_tdata,
    // moved, degenerate
    output logic [1:0]   o_m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    localparam int SqCells  = 33;
    localparam int DivCells = 32;

    logic signed [31:0] r_cx;
    logic signed [31:0] r_cy;
    logic [30:0]        r_wr;

    logic w_en;

    // configuration
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_wr <= WORLD_RADIUS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                IDX_CENTER_X: r_cx <= i_cfg_data;
                IDX_CENTER_Y: r_cy <= i_cfg_data;
                IDX_RADIUS:   r_wr <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // front stage: differences and magnitudes
    logic signed [32:0] w_vx;
    logic signed [32:0] w_vy;
    t_pay               n_p0;
    logic               r_v0;
    t_pay               r_p0;

    always_comb begin
        n_p0          = '0;
        n_p0.req_type = i_s_axis_tuser[0];
        n_p0.ax       = i_s_axis_tdata[31:0];
        n_p0.ay       = i_s_axis_tdata[63:32];
        n_p0.ar       = i_s_axis_tdata[87:64];
        n_p0.bx       = i_s_axis_tdata[119:88];
        n_p0.by       = i_s_axis_tdata[151:120];
        n_p0.rs       = {1'b0, i_s_axis_tdata[87:64]} + {1'b0, i_s_axis_tdata[175:152]};
        if (i_s_axis_tuser[0] == REQ_WORLD) begin
            w_vx = {n_p0.ax[31], n_p0.ax} - {r_cx[31], r_cx};
            w_vy = {n_p0.ay[31], n_p0.ay} - {r_cy[31], r_cy};
        end else begin
            w_vx = {n_p0.ax[31], n_p0.ax} - {n_p0.bx[31], n_p0.bx};
            w_vy = {n_p0.ay[31], n_p0.ay} - {n_p0.by[31], n_p0.by};
        end
        n_p0.sgn_x = w_vx[32];
        n_p0.sgn_y = w_vy[32];
        n_p0.mag_x = w_vx[32] ? 33'(-w_vx) : 33'(w_vx);
        n_p0.mag_y = w_vy[32] ? 33'(-w_vy) : 33'(w_vy);
    end

    // square stage
    logic        r_v1;
    t_pay        r_p1;
    logic [65:0] r_sx;
    logic [65:0] r_sy;
    logic [49:0] r_r2;

    // sum stage
    logic [64:0] w_sum;
    t_pay        n_p2;
    logic        r_v2;
    t_pay        r_p2;
    t_sq         r_sq2;

    always_comb begin
        w_sum     = {1'b0, r_sx[63:0]} + {1'b0, r_sy[63:0]};
        n_p2      = r_p1;
        n_p2.hit  = w_sum < {15'd0, r_r2};
        n_p2.zero = w_sum == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_s_axis_tvalid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p0       <= n_p0;
            r_p1       <= r_p0;
            r_sx       <= r_p0.mag_x * r_p0.mag_x;
            r_sy       <= r_p0.mag_y * r_p0.mag_y;
            r_r2       <= r_p0.rs * r_p0.rs;
            r_p2       <= n_p2;
            r_sq2.rad  <= {1'b0, w_sum};
            r_sq2.rem  <= '0;
            r_sq2.root <= '0;
        end
    end

    // square root chain
    logic w_sv [SqCells+1];
    t_pay w_sp [SqCells+1];
    t_sq  w_sq [SqCells+1];

    assign w_sv[0] = r_v2;
    assign w_sp[0] = r_p2;
    assign w_sq[0] = r_sq2;

    for (genvar g = 0; g < SqCells; g++) begin : g_sqrt
        pcr_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sv[g]),
            .i_pay   (w_sp[g]),
            .i_sq    (w_sq[g]),
            .o_valid (w_sv[g+1]),
            .o_pay   (w_sp[g+1]),
            .o_sq    (w_sq[g+1])
        );
    end

    // decision stage
    logic [32:0]        w_root;
    logic [25:0]        w_gap;
    logic signed [32:0] w_maxr;
    logic               w_out;
    t_pay               n_pd;
    logic               r_vd;
    t_pay               r_pd;

    always_comb begin
        n_pd   = w_sp[SqCells];
        w_root = w_sq[SqCells].root;
        w_gap  = {1'b0, n_pd.rs} - w_root[25:0];
        w_maxr = $signed({2'b00, r_wr}) - $signed({9'd0, n_pd.ar});
        w_out  = $signed({1'b0, w_root}) > $signed({w_maxr[32], w_maxr});
        if (n_pd.req_type == REQ_WORLD) begin
            n_pd.moved   = w_out && (w_root != '0);
            n_pd.degen   = w_out && (w_root == '0);
            n_pd.m_neg   = w_maxr[32];
            n_pd.m_mag   = w_maxr[32] ? 31'(-w_maxr) : w_maxr[30:0];
            n_pd.divisor = {1'b0, w_root};
        end else begin
            n_pd.moved   = n_pd.hit && !n_pd.zero;
            n_pd.degen   = n_pd.hit && n_pd.zero;
            n_pd.m_neg   = 1'b0;
            n_pd.m_mag   = {5'd0, w_gap};
            n_pd.divisor = {w_root, 1'b0};
        end
    end

    // multiply stage
    logic        r_vm;
    t_pay        r_pm;
    logic [63:0] r_nx;
    logic [63:0] r_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
            r_vm <= 1'b0;
        end else if (w_en) begin
            r_vd <= w_sv[SqCells];
            r_vm <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pd <= n_pd;
            r_pm <= r_pd;
            r_nx <= r_pd.mag_x * r_pd.m_mag;
            r_ny <= r_pd.mag_y * r_pd.m_mag;
        end
    end

    // divider chain; the quotient fits 32 bits, so the top half starts as remainder
    logic      w_dv [DivCells+1];
    t_pay      w_dp [DivCells+1];
    t_dl [1:0] w_dl [DivCells+1];

    assign w_dv[0]         = r_vm;
    assign w_dp[0]         = r_pm;
    assign w_dl[0][0].rem  = {3'd0, r_nx[63:32]};
    assign w_dl[0][0].num  = r_nx[31:0];
    assign w_dl[0][0].quo  = '0;
    assign w_dl[0][1].rem  = {3'd0, r_ny[63:32]};
    assign w_dl[0][1].num  = r_ny[31:0];
    assign w_dl[0][1].quo  = '0;

    for (genvar g = 0; g < DivCells; g++) begin : g_div
        pcr_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv[g]),
            .i_pay   (w_dp[g]),
            .i_dl    (w_dl[g]),
            .o_valid (w_dv[g+1]),
            .o_pay   (w_dp[g+1]),
            .o_dl    (w_dl[g+1])
        );
    end

    // final correction and saturation
    t_pay               w_fp;
    logic signed [33:0] w_cx;
    logic signed [33:0] w_cy;
    logic signed [33:0] w_nax;
    logic signed [33:0] w_nay;
    logic signed [33:0] w_nbx;
    logic signed [33:0] w_nby;

    always_comb begin
        w_fp  = w_dp[DivCells];
        w_cx  = (w_fp.sgn_x ^ w_fp.m_neg) ? -$signed({2'b00, w_dl[DivCells][0].quo})
                                          :  $signed({2'b00, w_dl[DivCells][0].quo});
        w_cy  = (w_fp.sgn_y ^ w_fp.m_neg) ? -$signed({2'b00, w_dl[DivCells][1].quo})
                                          :  $signed({2'b00, w_dl[DivCells][1].quo});
        w_nax = 34'(w_fp.ax);
        w_nay = 34'(w_fp.ay);
        w_nbx = 34'(w_fp.bx);
        w_nby = 34'(w_fp.by);
        if (w_fp.moved) begin
            if (w_fp.req_type == REQ_WORLD) begin
                w_nax = 34'(r_cx) + w_cx;
                w_nay = 34'(r_cy) + w_cy;
            end else begin
                w_nax = 34'(w_fp.ax) + w_cx;
                w_nay = 34'(w_fp.ay) + w_cy;
                w_nbx = 34'(w_fp.bx) - w_cx;
                w_nby = 34'(w_fp.by) - w_cy;
            end
        end
    end

    // output register
    logic               r_out_valid;
    logic [127:0]       r_out_data;
    logic [1:0]         r_out_user;
    logic               r_out_type;
    logic signed [31:0] r_out_bx;

    assign w_en = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dv[DivCells];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= {sat32(w_nby), sat32(w_nbx), sat32(w_nay), sat32(w_nax)};
            r_out_user <= {w_fp.degen, w_fp.moved};
            r_out_type <= w_fp.req_type;
            r_out_bx   <= w_fp.bx;
        end
    end

    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    `PCR_ASSERT_IMP(a_flags_excl, r_out_valid, !(r_out_user[0] && r_out_user[1]), "moved and degenerate together")
    `PCR_ASSERT_IMP(a_world_keeps_b, r_out_valid && (r_out_type == REQ_WORLD), r_out_data[95:64] == r_out_bx, "boundary result altered b")
    `PCR_ASSERT_IMP(a_ready_when_empty, !r_out_valid, o_s_axis_tready, "input stalled with empty output")
    `PCR_ASSERT_NXT(a_result_lands, w_dv[DivCells] && w_en, r_out_valid, "finished beat lost")

endmodule

// File: hdl/pcr_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per cell.
// Depends on pcr_pkg.
module pcr_sqrt_cell import pcr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_pay i_pay,
    input  t_sq  i_sq,
    output logic o_valid,
    output t_pay o_pay,
    output t_sq  o_sq
);

    logic        r_valid;
    t_pay        r_pay;
    t_sq         r_sq;
    t_sq         n_sq;
    logic [36:0] w_rem2;
    logic [36:0] w_trial;

    always_comb begin
        w_rem2   = {i_sq.rem, i_sq.rad[65:64]};
        w_trial  = {2'b00, i_sq.root, 2'b01};
        n_sq.rad = {i_sq.rad[63:0], 2'b00};
        if (w_rem2 >= w_trial) begin
            n_sq.rem  = 35'(w_rem2 - w_trial);
            n_sq.root = {i_sq.root[31:0], 1'b1};
        end else begin
            n_sq.rem  = w_rem2[34:0];
            n_sq.root = {i_sq.root[31:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pay <= i_pay;
            r_sq  <= n_sq;
        end
    end

    assign o_valid = r_valid;
    assign o_pay   = r_pay;
    assign o_sq    = r_sq;

endmodule

// File: hdl/pcr_div_cell.sv
// One cell of the divider chain: one quotient bit for the x and y lanes.
// Depends on pcr_pkg.
module pcr_div_cell import pcr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_pay      i_pay,
    input  t_dl [1:0] i_dl,
    output logic      o_valid,
    output t_pay      o_pay,
    output t_dl [1:0] o_dl
);

    logic        r_valid;
    t_pay        r_pay;
    t_dl [1:0]   r_dl;
    t_dl [1:0]   n_dl;
    logic [34:0] w_rem2 [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_rem2[k]     = {i_dl[k].rem[33:0], i_dl[k].num[31]};
            n_dl[k].num   = {i_dl[k].num[30:0], 1'b0};
            if (w_rem2[k] >= {1'b0, i_pay.divisor}) begin
                n_dl[k].rem = w_rem2[k] - {1'b0, i_pay.divisor};
                n_dl[k].quo = {i_dl[k].quo[30:0], 1'b1};
            end else begin
                n_dl[k].rem = w_rem2[k];
                n_dl[k].quo = {i_dl[k].quo[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pay <= i_pay;
            r_dl  <= n_dl;
        end
    end

    assign o_valid = r_valid;
    assign o_pay   = r_pay;
    assign o_dl    = r_dl;

endmodule
